FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Types and constants of the local search acceptance unit.
// ----------------------------------------------------------------------------
package lsa_pkg;

    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int COST_W     = 48;
    localparam int THR_W      = 40;
    localparam int LEN_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam int FRAC_W     = 8;
    localparam int CNT_W      = (PTR_W + 1 > LEN_W) ? PTR_W + 1 : LEN_W;

    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_ACCEPT = 2'd1;
    localparam logic [1:0] OP_ITER   = 2'd2;

    localparam logic MODE_LATE   = 1'b0;
    localparam logic MODE_RECORD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIST_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_THR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 2'd3;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [COST_W-1:0] start_cost;
        logic signed [COST_W-1:0] proposed_cost;
        logic signed [COST_W-1:0] present_cost;
    } in_word_t;

    typedef struct packed {
        logic                     accepted;
        logic signed [COST_W-1:0] best_seen;
    } out_word_t;

endpackage

FILE: rtl/local_search_acceptance_unit.sv
// A taken word passes the compare stage (s1) and the result register (m_valid).
// Throughput: one word per cycle unless m_ready stalls; the ring read at issue is
// registered, all other state updates at issue, so any operation may follow any.
// Stalls on m_ready hold both stages; s_ready falls only when both are full.
// Reset: synchronous active-low aresetn clears pointer, holds, valids and config
// (length 1); the cost ring is not cleared, entries are used only after the first lap.
// ----------------------------------------------------------------------------
// local_search_acceptance_unit
// Late acceptance / record-to-record acceptance test with a cost ring memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module local_search_acceptance_unit
    import lsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data
);

    logic                     mode_reg;
    logic [LEN_W-1:0]         list_length_reg;
    logic [THR_W-1:0]         initial_threshold_reg;
    logic [THR_W-1:0]         decay_step_reg;

    logic [PTR_W-1:0]         ring_pointer_reg, ring_pointer_next;
    logic                     first_lap_done_reg, first_lap_done_next;
    logic signed [COST_W-1:0] init_cost_hold_reg, init_cost_hold_next;
    logic [THR_W-1:0]         threshold_now_reg, threshold_now_next;
    logic signed [COST_W-1:0] best_cost_hold_reg, best_cost_hold_next;

    logic signed [COST_W-1:0] ring_mem [RING_DEPTH];
    logic signed [COST_W-1:0] ring_rd_reg;
    logic                     ring_we;

    logic                     s1_valid_reg, s1_valid_next;
    logic [1:0]               s1_op_reg;
    logic                     s1_mode_reg;
    logic                     s1_use_ring_reg;
    logic signed [COST_W-1:0] s1_init_cost_reg;
    logic signed [COST_W-1:0] s1_cand_reg;
    logic signed [COST_W-1:0] s1_cur_reg;
    logic signed [COST_W-1:0] s1_best_reg;
    logic [THR_W-1:0]         s1_thr_reg;

    logic                     m_valid_reg, m_valid_next;
    out_word_t                m_data_reg, m_data_next;

    logic                     s_fire;
    logic                     advance;
    logic [CNT_W-1:0]         eff_length;
    logic [CNT_W-1:0]         ptr_inc;
    logic signed [COST_W-1:0] past_cost;
    logic signed [COST_W:0]   rr_diff;
    logic                     la_acc;
    logic                     rr_acc;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg              <= MODE_LATE;
            list_length_reg       <= LEN_W'(1);
            initial_threshold_reg <= '0;
            decay_step_reg        <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:     mode_reg              <= cfg_wr_data[0];
                REG_LIST_LEN: list_length_reg       <= cfg_wr_data[LEN_W-1:0];
                REG_INIT_THR: initial_threshold_reg <= cfg_wr_data[THR_W-1:0];
                REG_DECAY:    decay_step_reg        <= cfg_wr_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (list_length_reg == '0) begin
            eff_length = CNT_W'(1);
        end else if (CNT_W'(list_length_reg) > CNT_W'(RING_DEPTH)) begin
            eff_length = CNT_W'(RING_DEPTH);
        end else begin
            eff_length = CNT_W'(list_length_reg);
        end
    end

    assign ptr_inc = CNT_W'(ring_pointer_reg) + CNT_W'(1);

    // issue stage: scheme state update
    always_comb begin
        ring_pointer_next   = ring_pointer_reg;
        first_lap_done_next = first_lap_done_reg;
        init_cost_hold_next = init_cost_hold_reg;
        threshold_now_next  = threshold_now_reg;
        best_cost_hold_next = best_cost_hold_reg;
        ring_we             = 1'b0;
        if (s_fire) begin
            unique case (s_data.operation)
                OP_INIT: begin
                    ring_pointer_next   = '0;
                    first_lap_done_next = 1'b0;
                    init_cost_hold_next = s_data.start_cost;
                    best_cost_hold_next = s_data.start_cost;
                    threshold_now_next  = initial_threshold_reg;
                end
                OP_ACCEPT: begin
                    if (mode_reg == MODE_RECORD &&
                        s_data.proposed_cost < best_cost_hold_reg) begin
                        best_cost_hold_next = s_data.proposed_cost;
                    end
                end
                OP_ITER: begin
                    if (mode_reg == MODE_LATE) begin
                        ring_we = 1'b1;
                        if (ptr_inc >= eff_length) begin
                            ring_pointer_next   = '0;
                            first_lap_done_next = 1'b1;
                        end else begin
                            ring_pointer_next = ptr_inc[PTR_W-1:0];
                        end
                    end else if (threshold_now_reg > decay_step_reg) begin
                        threshold_now_next = threshold_now_reg - decay_step_reg;
                    end else begin
                        threshold_now_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_pointer_reg   <= '0;
            first_lap_done_reg <= 1'b0;
            init_cost_hold_reg <= '0;
            threshold_now_reg  <= '0;
            best_cost_hold_reg <= '0;
        end else begin
            ring_pointer_reg   <= ring_pointer_next;
            first_lap_done_reg <= first_lap_done_next;
            init_cost_hold_reg <= init_cost_hold_next;
            threshold_now_reg  <= threshold_now_next;
            best_cost_hold_reg <= best_cost_hold_next;
        end
    end

    // cost ring
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_pointer_reg] <= s_data.present_cost;
        end
        if (s_fire) begin
            ring_rd_reg <= ring_mem[ring_pointer_reg];
        end
    end

    // compare stage
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_op_reg        <= s_data.operation;
            s1_mode_reg      <= mode_reg;
            s1_use_ring_reg  <= first_lap_done_reg;
            s1_init_cost_reg <= init_cost_hold_reg;
            s1_cand_reg      <= s_data.proposed_cost;
            s1_cur_reg       <= s_data.present_cost;
            s1_best_reg      <= best_cost_hold_next;
            s1_thr_reg       <= threshold_now_reg;
        end
    end

    assign past_cost = s1_use_ring_reg ? ring_rd_reg : s1_init_cost_reg;
    assign la_acc    = (s1_cand_reg <= past_cost) || (s1_cand_reg <= s1_cur_reg);
    assign rr_diff   = (COST_W+1)'(s1_cand_reg) - (COST_W+1)'(s1_best_reg);
    assign rr_acc    = (rr_diff[COST_W:THR_W-FRAC_W] == '0) &&
                       ({rr_diff[THR_W-FRAC_W-1:0], FRAC_W'(0)} <= s1_thr_reg);

    always_comb begin
        m_data_next.best_seen = s1_best_reg;
        m_data_next.accepted  = (s1_op_reg == OP_ACCEPT) &&
                                ((s1_mode_reg == MODE_RECORD) ? rr_acc : la_acc);
        s1_valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        m_valid_next  = advance ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    `ASSERT_NEXT(a_init_clears_ring_state,
        s_fire && s_data.operation == OP_INIT,
        ring_pointer_reg == '0 && !first_lap_done_reg)
    `ASSERT_NEXT(a_only_tests_accept,
        advance && s1_valid_reg && s1_op_reg != OP_ACCEPT,
        !m_data_reg.accepted)
    `ASSERT_NEXT(a_best_never_rises,
        s_fire && s_data.operation != OP_INIT,
        best_cost_hold_reg <= $past(best_cost_hold_reg))
    `ASSERT_IMPL(a_full_pipe_blocks,
        s1_valid_reg && m_valid_reg && !m_ready,
        !s_ready)

endmodule

FILE: tb/sv/lsa_checker.sv
// ----------------------------------------------------------------------------
// lsa_checker
// Watches the configuration port and both word channels of the local search
// acceptance unit. Keeps its own copy of the late acceptance ring and the
// record-to-record threshold state, predicts the result word of every input
// word taken, and compares each result word field by field with the oldest
// prediction. Reports the number of failures and of words still owed.
// ----------------------------------------------------------------------------
module lsa_checker
    import lsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_word_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_word_t             m_data,
    output int                    fail_count,
    output int                    words_owed
);

    logic                     mode_sel;
    logic [LEN_W-1:0]         ring_len;
    logic [THR_W-1:0]         start_thr;
    logic [THR_W-1:0]         thr_decay;

    logic signed [COST_W-1:0] cost_hist [RING_DEPTH];
    int unsigned              hist_ptr;
    bit                       lap_done;
    logic signed [COST_W-1:0] init_hold;
    logic signed [COST_W-1:0] best_hold;
    logic [THR_W-1:0]         thr_left;

    out_word_t                owed_words [$];
    int                       fails = 0;

    initial begin
        fail_count = 0;
        words_owed = 0;
    end

    function automatic out_word_t judge_word(in_word_t w);
        logic signed [COST_W-1:0] cand;
        logic signed [COST_W-1:0] cur;
        logic signed [COST_W-1:0] past;
        longint                   lhs;
        longint                   rhs;
        longint                   thr_l;
        int unsigned              eff_len;
        int unsigned              slot;
        out_word_t                r;
        cand = w.proposed_cost;
        cur  = w.present_cost;
        if (ring_len == 0) begin
            eff_len = 1;
        end else if (ring_len > RING_DEPTH) begin
            eff_len = RING_DEPTH;
        end else begin
            eff_len = 32'(ring_len);
        end
        slot = hist_ptr % RING_DEPTH;
        r.accepted = 1'b0;
        case (w.operation)
            OP_INIT: begin
                hist_ptr  = 0;
                lap_done  = 1'b0;
                init_hold = w.start_cost;
                best_hold = w.start_cost;
                thr_left  = start_thr;
            end
            OP_ACCEPT: begin
                if (mode_sel == MODE_LATE) begin
                    past = lap_done ? cost_hist[slot] : init_hold;
                    r.accepted = (cand <= past) || (cand <= cur);
                end else begin
                    if (cand < best_hold)
                        best_hold = cand;
                    thr_l = thr_left;
                    lhs = longint'(cand) <<< FRAC_W;
                    rhs = (longint'(best_hold) <<< FRAC_W) + thr_l;
                    r.accepted = (lhs <= rhs);
                end
            end
            OP_ITER: begin
                if (mode_sel == MODE_LATE) begin
                    cost_hist[slot] = cur;
                    if (slot + 1 >= eff_len) begin
                        hist_ptr = 0;
                        lap_done = 1'b1;
                    end else begin
                        hist_ptr = slot + 1;
                    end
                end else begin
                    thr_left = (thr_left > thr_decay) ? thr_left - thr_decay : '0;
                end
            end
            default: ;
        endcase
        r.best_seen = best_hold;
        return r;
    endfunction

    always @(posedge aclk) begin
        out_word_t due;
        if (!aresetn) begin
            mode_sel  = MODE_LATE;
            ring_len  = LEN_W'(1);
            start_thr = '0;
            thr_decay = '0;
            hist_ptr  = 0;
            lap_done  = 1'b0;
            init_hold = '0;
            best_hold = '0;
            thr_left  = '0;
            owed_words.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MODE:     mode_sel  = cfg_wr_data[0];
                    REG_LIST_LEN: ring_len  = cfg_wr_data[LEN_W-1:0];
                    REG_INIT_THR: start_thr = cfg_wr_data[THR_W-1:0];
                    REG_DECAY:    thr_decay = cfg_wr_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                owed_words.push_back(judge_word(s_data));
            if (m_valid && m_ready) begin
                if (owed_words.size() == 0) begin
                    $error("result word with nothing owed: accepted %0b best_seen %0d",
                           m_data.accepted, $signed(m_data.best_seen));
                    fails++;
                end else begin
                    due = owed_words.pop_front();
                    if (m_data.accepted !== due.accepted) begin
                        $error("accepted: expected %0b, got %0b",
                               due.accepted, m_data.accepted);
                        fails++;
                    end
                    if (m_data.best_seen !== due.best_seen) begin
                        $error("best_seen: expected %0d, got %0d",
                               $signed(due.best_seen), $signed(m_data.best_seen));
                        fails++;
                    end
                end
            end
        end
        fail_count <= fails;
        words_owed <= owed_words.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the local search acceptance unit. Runs a short
// directed sequence over both schemes and the corner cases of ring length,
// threshold and decay, fills the whole cost ring once, then random phases
// of init / accept / iteration words under changing configuration, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
    import lsa_pkg::*;

    localparam int                       IDLE_LIMIT  = 2000;
    localparam int                       WORD_TARGET = 1450;
    localparam logic signed [COST_W-1:0] COST_MAX    = {1'b0, {(COST_W-1){1'b1}}};
    localparam logic signed [COST_W-1:0] COST_MIN    = {1'b1, {(COST_W-1){1'b0}}};
    localparam logic [THR_W-1:0]         THR_MAX     = '1;
    localparam logic [1:0]               OP_SPARE    = 2'd3;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_MODE;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    in_word_t              s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    out_word_t             m_data;

    int                    fail_count;
    int                    words_owed;
    int                    words_sent  = 0;
    int                    idle_cycles = 0;
    bit                    calm        = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    local_search_acceptance_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    lsa_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .words_owed  (words_owed)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic logic signed [COST_W-1:0] pick_cost(logic signed [COST_W-1:0] base);
        logic signed [COST_W-1:0] delta;
        logic [63:0]              raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return COST_MAX;
            1: return COST_MIN;
            2, 3: return raw[COST_W-1:0];
            default: begin
                delta = raw[COST_W-1:0];
                delta = delta >>> $urandom_range(13, 47);
                return base + delta;
            end
        endcase
    endfunction

    function automatic logic [THR_W-1:0] pick_thr();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return '0;
            1: return THR_MAX;
            default: return raw[THR_W-1:0] >> $urandom_range(0, 39);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return LEN_W'(1);
            2: return LEN_W'(RING_DEPTH);
            3: return LEN_W'($urandom_range(RING_DEPTH + 1, (1 << LEN_W) - 1));
            4: return LEN_W'($urandom);
            default: return LEN_W'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic send_word(input logic [1:0] op, input logic signed [COST_W-1:0] st,
                             input logic signed [COST_W-1:0] cd,
                             input logic signed [COST_W-1:0] cu);
        int       gap;
        in_word_t w;
        gap = calm ? 0 : $urandom_range(0, 12);
        w.operation     = op;
        w.start_cost    = st;
        w.proposed_cost = cd;
        w.present_cost  = cu;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (op != OP_SPARE)
            words_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (words_owed != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_directed();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_LATE));
        write_reg(REG_LIST_LEN, CFG_DATA_W'(3));
        write_reg(REG_INIT_THR, CFG_DATA_W'('h100));
        write_reg(REG_DECAY, CFG_DATA_W'('h80));
        send_word(OP_INIT, -48'sd5, 48'sd0, 48'sd0);
        send_word(OP_ACCEPT, 48'sd0, -48'sd5, COST_MIN);
        send_word(OP_ACCEPT, 48'sd0, -48'sd4, -48'sd4);
        send_word(OP_ACCEPT, 48'sd0, -48'sd4, -48'sd10);
        send_word(OP_ITER, COST_MAX, COST_MAX, COST_MIN);
        send_word(OP_ITER, COST_MIN, COST_MIN, COST_MAX);
        send_word(OP_ACCEPT, 48'sd0, COST_MAX, COST_MIN);
        send_word(OP_ITER, 48'sd0, 48'sd0, 48'sd7);
        send_word(OP_ACCEPT, 48'sd0, COST_MIN, COST_MAX);
        send_word(OP_ACCEPT, 48'sd0, 48'sd0, -48'sd1);
        send_word(OP_SPARE, '1, '1, '1);
        send_word(OP_ITER, 48'sd0, 48'sd0, 48'sd5);
        settle();
        // shrink below the pointer
        write_reg(REG_LIST_LEN, CFG_DATA_W'(0));
        send_word(OP_ACCEPT, 48'sd0, 48'sd7, COST_MIN);
        send_word(OP_ITER, 48'sd0, 48'sd0, 48'sd9);
        send_word(OP_ACCEPT, 48'sd0, COST_MAX, COST_MAX);
        settle();
        write_reg(REG_LIST_LEN, CFG_DATA_W'(300));
        send_word(OP_INIT, COST_MAX, 48'sd0, 48'sd0);
        send_word(OP_ACCEPT, 48'sd0, COST_MAX, COST_MIN);
        send_word(OP_ITER, 48'sd0, 48'sd0, 48'sd1);
        settle();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_RECORD));
        write_reg(REG_INIT_THR, THR_MAX);
        write_reg(REG_DECAY, THR_MAX);
        send_word(OP_INIT, 48'sd0, COST_MIN, COST_MAX);
        send_word(OP_ACCEPT, 48'sd0, 48'sd4294967295, 48'sd0);
        send_word(OP_ACCEPT, 48'sd0, 48'sd4294967296, 48'sd0);
        send_word(OP_ITER, 48'sd0, 48'sd0, 48'sd0);
        send_word(OP_ACCEPT, 48'sd0, 48'sd0, 48'sd0);
        send_word(OP_ACCEPT, 48'sd0, COST_MIN, 48'sd0);
        send_word(OP_ITER, 48'sd0, 48'sd0, 48'sd0);
        send_word(OP_ACCEPT, 48'sd0, COST_MIN + 48'sd1, 48'sd0);
        settle();
    endtask

    task automatic fill_ring();
        logic signed [COST_W-1:0] walk;
        write_reg(REG_MODE, CFG_DATA_W'(MODE_LATE));
        write_reg(REG_LIST_LEN, CFG_DATA_W'(RING_DEPTH));
        walk = pick_cost(48'sd0);
        send_word(OP_INIT, walk, pick_cost(walk), pick_cost(walk));
        for (int i = 0; i < RING_DEPTH; i++) begin
            send_word(OP_ACCEPT, pick_cost(walk), pick_cost(walk), walk);
            walk = pick_cost(walk);
            send_word(OP_ITER, pick_cost(walk), pick_cost(walk), walk);
        end
        settle();
    endtask

    task automatic random_phase();
        logic signed [COST_W-1:0] walk;
        logic [63:0]              raw;
        int                       n;
        int                       pick;
        settle();
        if ($urandom_range(0, 1))
            write_reg(REG_MODE,
                      CFG_DATA_W'($urandom_range(0, 1) ? MODE_RECORD : MODE_LATE));
        if ($urandom_range(0, 1))
            write_reg(REG_LIST_LEN, CFG_DATA_W'(pick_len()));
        if ($urandom_range(0, 1))
            write_reg(REG_INIT_THR, pick_thr());
        if ($urandom_range(0, 1))
            write_reg(REG_DECAY, pick_thr() >> $urandom_range(0, 12));
        calm = ($urandom_range(0, 3) == 0);
        walk = pick_cost(48'sd0);
        if ($urandom_range(0, 3) != 0)
            send_word(OP_INIT, walk, pick_cost(walk), pick_cost(walk));
        n = $urandom_range(40, 140);
        repeat (n) begin
            pick = $urandom_range(0, 19);
            raw  = {$urandom, $urandom};
            if (pick == 0) begin
                send_word(OP_SPARE, raw[COST_W-1:0], pick_cost(walk), pick_cost(walk));
            end else if (pick == 1) begin
                walk = pick_cost(walk);
                send_word(OP_INIT, walk, pick_cost(walk), pick_cost(walk));
            end else if (pick < 7) begin
                walk = pick_cost(walk);
                send_word(OP_ITER, pick_cost(walk), pick_cost(walk), walk);
            end else begin
                send_word(OP_ACCEPT, pick_cost(walk), pick_cost(walk), walk);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        fill_ring();
        while (words_sent < WORD_TARGET)
            random_phase();
        settle();
        if (fail_count == 0 && words_owed == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lsa_pkg.sv
rtl/local_search_acceptance_unit.sv
tb/sv/lsa_checker.sv
tb/sv/tb_top.sv
